// ===== sv/edvd_pkg.sv =====
// Shared widths and constants for the Epstein drag damping pipeline.
`timescale 1ns / 1ps
package edvd_pkg;
    localparam int unsigned WORD_W    = 32;
    localparam int unsigned FRAC_W    = 16;
    localparam int unsigned RAD_W     = 48;
    localparam int unsigned ROOT_W    = 24;
    localparam int unsigned DIV_W     = 33;
    localparam int unsigned QUOT_W    = 33;
    localparam logic [WORD_W-1:0] G_SAT = '1;
endpackage

// ===== sv/edvd_sqrt.sv =====
// Pipelined integer square root, one root bit per stage.
`timescale 1ns / 1ps
module edvd_sqrt
    import edvd_pkg::*;
#(
    parameter int unsigned SB_W = 8
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  logic              in_vld,
    input  logic [RAD_W-1:0]  in_rad,
    input  logic [SB_W-1:0]   in_sb,
    output logic              out_vld,
    output logic [ROOT_W-1:0] out_root,
    output logic [SB_W-1:0]   out_sb
);
    localparam int unsigned REM_W = ROOT_W + 3;

    logic              vld_reg  [0:ROOT_W];
    logic [RAD_W-1:0]  rad_reg  [0:ROOT_W];
    logic [REM_W-1:0]  rem_reg  [0:ROOT_W];
    logic [ROOT_W-1:0] root_reg [0:ROOT_W];
    logic [SB_W-1:0]   sb_reg   [0:ROOT_W];

    // Stage zero is the input
    always_comb begin
        vld_reg[0]  = in_vld;
        rad_reg[0]  = in_rad;
        rem_reg[0]  = '0;
        root_reg[0] = '0;
        sb_reg[0]   = in_sb;
    end

    for (genvar k = 1; k <= ROOT_W; k++) begin : g_stage
        logic [REM_W-1:0] sh_next;
        logic [REM_W-1:0] trial_next;

        // Bring down two radicand bits and try the next root bit
        always_comb begin
            sh_next    = {rem_reg[k-1][REM_W-3:0], rad_reg[k-1][RAD_W-1 -: 2]};
            trial_next = {1'b0, root_reg[k-1], 2'b01};
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[k] <= 1'b0;
            end else if (en) begin
                vld_reg[k] <= vld_reg[k-1];
            end
            if (en) begin
                rad_reg[k] <= {rad_reg[k-1][RAD_W-3:0], 2'b00};
                sb_reg[k]  <= sb_reg[k-1];
                if (sh_next >= trial_next) begin
                    rem_reg[k]  <= sh_next - trial_next;
                    root_reg[k] <= {root_reg[k-1][ROOT_W-2:0], 1'b1};
                end else begin
                    rem_reg[k]  <= sh_next;
                    root_reg[k] <= {root_reg[k-1][ROOT_W-2:0], 1'b0};
                end
            end
        end
    end

    assign out_vld  = vld_reg[ROOT_W];
    assign out_root = root_reg[ROOT_W];
    assign out_sb   = sb_reg[ROOT_W];
endmodule

// ===== sv/edvd_recip.sv =====
// Pipelined restoring divider forming 2^48 / d, one quotient bit per stage.
`timescale 1ns / 1ps
module edvd_recip
    import edvd_pkg::*;
#(
    parameter int unsigned SB_W = 8
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  logic              in_vld,
    input  logic [DIV_W-1:0]  in_div,
    input  logic [SB_W-1:0]   in_sb,
    output logic              out_vld,
    output logic [QUOT_W-1:0] out_quot,
    output logic [SB_W-1:0]   out_sb
);
    // Numerator 2^48: top part 2^15 enters first, lower bits are zero
    localparam logic [DIV_W-1:0] REM_INIT = DIV_W'(1) << (RAD_W - QUOT_W);

    logic              vld_reg  [0:QUOT_W];
    logic [DIV_W-1:0]  div_reg  [0:QUOT_W];
    logic [DIV_W-1:0]  rem_reg  [0:QUOT_W];
    logic [QUOT_W-1:0] quot_reg [0:QUOT_W];
    logic [SB_W-1:0]   sb_reg   [0:QUOT_W];

    always_comb begin
        vld_reg[0]  = in_vld;
        div_reg[0]  = in_div;
        rem_reg[0]  = REM_INIT;
        quot_reg[0] = '0;
        sb_reg[0]   = in_sb;
    end

    for (genvar k = 1; k <= QUOT_W; k++) begin : g_stage
        logic [DIV_W:0] sh_next;

        // Shift in a zero numerator bit and subtract if it fits
        assign sh_next = {rem_reg[k-1], 1'b0};

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[k] <= 1'b0;
            end else if (en) begin
                vld_reg[k] <= vld_reg[k-1];
            end
            if (en) begin
                div_reg[k] <= div_reg[k-1];
                sb_reg[k]  <= sb_reg[k-1];
                if (sh_next >= {1'b0, div_reg[k-1]}) begin
                    rem_reg[k]  <= DIV_W'(sh_next - {1'b0, div_reg[k-1]});
                    quot_reg[k] <= {quot_reg[k-1][QUOT_W-2:0], 1'b1};
                end else begin
                    rem_reg[k]  <= sh_next[DIV_W-1:0];
                    quot_reg[k] <= {quot_reg[k-1][QUOT_W-2:0], 1'b0};
                end
            end
        end
    end

    assign out_vld  = vld_reg[QUOT_W];
    assign out_quot = quot_reg[QUOT_W];
    assign out_sb   = sb_reg[QUOT_W];

    // The factor never exceeds 2^32
    a_quot_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        out_vld && out_quot[QUOT_W-1] |-> out_quot[QUOT_W-2:0] == '0)
        else $error("reciprocal above 2^32");
    // A valid stage never comes out of nowhere
    a_vld_src: assert property (@(posedge aclk) disable iff (!aresetn)
        en && !vld_reg[QUOT_W-1] |=> !out_vld)
        else $error("divider valid without source");
endmodule

// ===== sv/epstein_drag_velocity_damping.sv =====
// Top level: Epstein drag implicit momentum damping, Q16.16 stream pipeline.
// Each word passes stage 1, the square root, stages g1 and g2, the divider, m1 and m2.
// Throughput: one word per cycle; the 24-stage square root and the 33-stage
// reciprocal divider each take one item per cycle, and a stall freezes all stages.
// Reset (aresetn low, synchronous) clears all valid bits and the coefficient to 0.
`timescale 1ns / 1ps
module epstein_drag_velocity_damping
    import edvd_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_we,
    input  logic [31:0]  cfg_wdata,     // drag_coefficient, unsigned Q16.16
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [159:0] s_tdata,       // density, temperature, mom_x_in, mom_y_in, mom_z_in
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [95:0]  m_tdata,       // mom_x_out, mom_y_out, mom_z_out
    output logic         m_tuser        // skipped
);
    localparam int unsigned MOM_W   = 3 * WORD_W;
    localparam int unsigned SQ_SB_W = 1 + WORD_W + MOM_W + 1;
    localparam int unsigned DV_SB_W = MOM_W + 1;
    localparam int unsigned PROD_W  = 2 * WORD_W + 1;

    logic              en;
    logic [WORD_W-1:0] coeff_reg;

    logic signed [WORD_W-1:0] dens;
    logic signed [WORD_W-1:0] temp;

    logic                 s1_vld_reg;
    logic [2*WORD_W-1:0]  s1_prod_reg;
    logic [RAD_W-1:0]     s1_rad_reg;
    logic [MOM_W-1:0]     s1_mom_reg;
    logic                 s1_skip_reg;

    logic              sq_vld;
    logic [ROOT_W-1:0] sq_root;
    logic [SQ_SB_W-1:0] sq_sb;
    logic              sq_pover;
    logic [WORD_W-1:0] sq_p;
    logic [MOM_W-1:0]  sq_mom;
    logic              sq_skip;

    logic                      g1_vld_reg;
    logic [WORD_W+ROOT_W-1:0]  g1_prod_reg;
    logic                      g1_pover_reg;
    logic [MOM_W-1:0]          g1_mom_reg;
    logic                      g1_skip_reg;

    logic              g2_vld_reg;
    logic [DIV_W-1:0]  g2_div_reg;
    logic [MOM_W-1:0]  g2_mom_reg;
    logic              g2_skip_reg;
    logic [WORD_W-1:0] g_sat;

    logic              dv_vld;
    logic [QUOT_W-1:0] dv_quot;
    logic [DV_SB_W-1:0] dv_sb;

    logic              m1_vld_reg;
    logic [PROD_W-1:0] m1_prod_reg [0:2];
    logic [2:0]        m1_neg_reg;
    logic [MOM_W-1:0]  m1_mom_reg;
    logic              m1_skip_reg;

    logic              m2_vld_reg;
    logic [MOM_W-1:0]  m2_data_reg;
    logic              m2_skip_reg;

    // Advance the whole pipeline unless the output word is stalled
    assign en       = !m2_vld_reg || m_tready;
    assign s_tready = en;

    // Hold the coefficient register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            coeff_reg <= '0;
        end else if (cfg_we) begin
            coeff_reg <= cfg_wdata;
        end
    end

    assign dens = s_tdata[WORD_W-1:0];
    assign temp = s_tdata[2*WORD_W-1:WORD_W];

    // Stage 1: coefficient times density, radicand, skip test
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_vld_reg <= 1'b0;
        end else if (en) begin
            s1_vld_reg <= s_tvalid;
        end
        if (en) begin
            s1_prod_reg <= (2*WORD_W)'(coeff_reg) * (2*WORD_W)'(dens[WORD_W-1:0]);
            s1_rad_reg  <= {temp[WORD_W-1:0], FRAC_W'(0)};
            s1_mom_reg  <= s_tdata[5*WORD_W-1:2*WORD_W];
            s1_skip_reg <= (dens <= 0) || (temp <= 0);
        end
    end

    edvd_sqrt #(.SB_W(SQ_SB_W)) u_sqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_vld   (s1_vld_reg),
        .in_rad   (s1_rad_reg),
        .in_sb    ({s1_skip_reg, s1_mom_reg, s1_prod_reg[2*WORD_W-1:FRAC_W+WORD_W] != '0,
                    s1_prod_reg[FRAC_W+WORD_W-1:FRAC_W]}),
        .out_vld  (sq_vld),
        .out_root (sq_root),
        .out_sb   (sq_sb)
    );

    assign {sq_skip, sq_mom, sq_pover, sq_p} = sq_sb;

    // Stage g1: p times sqrt(T)
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            g1_vld_reg <= 1'b0;
        end else if (en) begin
            g1_vld_reg <= sq_vld;
        end
        if (en) begin
            g1_prod_reg  <= (WORD_W+ROOT_W)'(sq_p) * (WORD_W+ROOT_W)'(sq_root);
            g1_pover_reg <= sq_pover;
            g1_mom_reg   <= sq_mom;
            g1_skip_reg  <= sq_skip;
        end
    end

    // Saturate g at 32 bits
    assign g_sat = (g1_pover_reg || g1_prod_reg[WORD_W+ROOT_W-1:WORD_W+FRAC_W] != '0)
                   ? G_SAT : g1_prod_reg[WORD_W+FRAC_W-1:FRAC_W];

    // Stage g2: divisor 1 + g
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            g2_vld_reg <= 1'b0;
        end else if (en) begin
            g2_vld_reg <= g1_vld_reg;
        end
        if (en) begin
            g2_div_reg  <= {1'b0, g_sat} + (DIV_W'(1) << FRAC_W);
            g2_mom_reg  <= g1_mom_reg;
            g2_skip_reg <= g1_skip_reg;
        end
    end

    edvd_recip #(.SB_W(DV_SB_W)) u_recip (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_vld   (g2_vld_reg),
        .in_div   (g2_div_reg),
        .in_sb    ({g2_skip_reg, g2_mom_reg}),
        .out_vld  (dv_vld),
        .out_quot (dv_quot),
        .out_sb   (dv_sb)
    );

    // Stage m1: magnitude times factor for each component
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m1_vld_reg <= 1'b0;
        end else if (en) begin
            m1_vld_reg <= dv_vld;
        end
        if (en) begin
            m1_mom_reg  <= dv_sb[MOM_W-1:0];
            m1_skip_reg <= dv_sb[MOM_W];
        end
    end

    for (genvar c = 0; c < 3; c++) begin : g_mul
        logic [WORD_W-1:0] comp;
        logic [WORD_W-1:0] mag;

        assign comp = dv_sb[c*WORD_W +: WORD_W];
        assign mag  = comp[WORD_W-1] ? (~comp + WORD_W'(1)) : comp;

        always_ff @(posedge aclk) begin
            if (en) begin
                m1_prod_reg[c] <= PROD_W'(mag) * PROD_W'(dv_quot);
                m1_neg_reg[c]  <= comp[WORD_W-1];
            end
        end
    end

    // Stage m2: round, restore sign, pick the pass-through for skipped words
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m2_vld_reg <= 1'b0;
        end else if (en) begin
            m2_vld_reg <= m1_vld_reg;
        end
        if (en) begin
            m2_skip_reg <= m1_skip_reg;
            for (int c = 0; c < 3; c++) begin
                logic [PROD_W-1:0] rnd;
                logic [WORD_W-1:0] r;
                rnd = m1_prod_reg[c] + (PROD_W'(1) << (WORD_W - 1));
                r   = rnd[2*WORD_W-1:WORD_W];
                if (m1_skip_reg) begin
                    m2_data_reg[c*WORD_W +: WORD_W] <= m1_mom_reg[c*WORD_W +: WORD_W];
                end else if (m1_neg_reg[c]) begin
                    m2_data_reg[c*WORD_W +: WORD_W] <= ~r + WORD_W'(1);
                end else begin
                    m2_data_reg[c*WORD_W +: WORD_W] <= r;
                end
            end
        end
    end

    assign m_tvalid = m2_vld_reg;
    assign m_tdata  = m2_data_reg;
    assign m_tuser  = m2_skip_reg;

    // A stalled output word blocks new input words
    a_no_accept_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("input accepted while output stalled");
    // A stalled stage-one word stays put
    a_s1_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !en |=> $stable(s1_vld_reg) && $stable(s1_skip_reg))
        else $error("stage one moved during stall");
    // An accepted word reaches stage one
    a_s1_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> s1_vld_reg)
        else $error("accepted word lost at stage one");
endmodule

// ===== bench/tb_epstein_drag_velocity_damping.sv =====
// Self-checking testbench for the Epstein drag momentum damping pipeline.
`timescale 1ns / 1ps
module tb_epstein_drag_velocity_damping;
    import edvd_pkg::*;

    typedef struct packed {
        logic [31:0] mz;
        logic [31:0] my;
        logic [31:0] mx;
        logic [31:0] temp;
        logic [31:0] dens;
    } particle_t;

    typedef struct packed {
        logic        skip;
        logic [31:0] mz;
        logic [31:0] my;
        logic [31:0] mx;
    } damped_t;

    logic         aclk = 0;
    logic         aresetn = 0;
    logic         cfg_we = 0;
    logic [31:0]  cfg_wdata = '0;
    logic         s_tvalid = 0;
    logic         s_tready;
    logic [159:0] s_tdata = '0;     // density, temperature, mom_x_in, mom_y_in, mom_z_in
    logic         m_tvalid;
    logic         m_tready = 0;
    logic [95:0]  m_tdata;          // mom_x_out, mom_y_out, mom_z_out
    logic         m_tuser;          // skipped

    logic [31:0]  coeff = '0;
    damped_t      damped_q[$];
    int           n_err = 0;
    int           n_res = 0;
    int           n_damped = 0;
    int           n_skip = 0;
    bit           idle_on = 1;      // random gaps allowed
    int           hold_off = 0;     // forced receiver stall length

    epstein_drag_velocity_damping dut (
        .aclk, .aresetn, .cfg_we, .cfg_wdata,
        .s_tvalid, .s_tready, .s_tdata,
        .m_tvalid, .m_tready, .m_tdata, .m_tuser
    );

    always #5 aclk = ~aclk;

    // Bit-by-bit integer square root of a 48-bit radicand
    function automatic logic [23:0] root48(input logic [47:0] v);
        logic [63:0] rem;
        logic [63:0] res;
        logic [63:0] bitv;
        rem = v;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > rem) bitv >>= 2;
        while (bitv != 0) begin
            if (rem >= res + bitv) begin
                rem = rem - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return res[23:0];
    endfunction

    // Scale one signed component by the Q1.32 factor, ties away from zero
    function automatic logic [31:0] damp_comp(input logic [31:0] m, input logic [32:0] f);
        logic [32:0] mag;
        logic [65:0] prod;
        logic [31:0] r;
        mag = m[31] ? (33'h1_0000_0000 - m) : {1'b0, m};
        prod = mag * f + 66'h8000_0000;
        r = prod[63:32];
        return m[31] ? -r : r;
    endfunction

    function automatic damped_t predict_damping(input particle_t p);
        damped_t     d;
        logic [63:0] prod;
        logic [63:0] gw;
        logic [31:0] g;
        logic [32:0] f;
        logic [23:0] sq;
        if ($signed(p.dens) <= 0 || $signed(p.temp) <= 0) begin
            d.mx = p.mx; d.my = p.my; d.mz = p.mz; d.skip = 1;
            return d;
        end
        sq = root48({p.temp, 16'h0});
        prod = (64'(coeff) * 64'(p.dens)) >> 16;
        if (prod[63:32] != 0) begin
            g = G_SAT;
        end else begin
            gw = (prod * 64'(sq)) >> 16;
            g = (gw[63:32] != 0) ? G_SAT : gw[31:0];
        end
        f = 33'((64'd1 << 48) / (64'd65536 + 64'(g)));
        d.mx = damp_comp(p.mx, f);
        d.my = damp_comp(p.my, f);
        d.mz = damp_comp(p.mz, f);
        d.skip = 0;
        return d;
    endfunction

    // Offer one word, hold until accepted, then log its expectation
    task automatic send_particle(input particle_t p);
        while (idle_on && $urandom_range(99) < 14) begin
            s_tvalid <= 0;
            @(posedge aclk);
        end
        s_tvalid <= 1;
        s_tdata  <= p;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        damped_q.push_back(predict_damping(p));
    endtask

    // Stop offering and wait until every expected result has come
    task automatic drain();
        s_tvalid <= 0;
        while (damped_q.size() != 0) @(posedge aclk);
        repeat (70) @(posedge aclk);
    endtask

    task automatic write_coeff(input logic [31:0] c);
        drain();
        cfg_we <= 1;
        cfg_wdata <= c;
        @(posedge aclk);
        cfg_we <= 0;
        coeff = c;
    endtask

    function automatic logic [31:0] rnd_field();
        case ($urandom_range(5))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return $urandom_range(32'h0004_0000);
            3: return -$urandom_range(32'h0004_0000);
            default: return $urandom;
        endcase
    endfunction

    function automatic particle_t rnd_particle(input bit valid_bias);
        particle_t p;
        p.dens = rnd_field(); p.temp = rnd_field();
        p.mx = rnd_field(); p.my = rnd_field(); p.mz = rnd_field();
        if (valid_bias && $urandom_range(9) < 8) begin
            p.dens = $urandom_range(32'h7FFF_FFFF, 1) >> $urandom_range(31);
            p.temp = $urandom_range(32'h7FFF_FFFF, 1) >> $urandom_range(31);
            if (p.dens == 0) p.dens = 1;
            if (p.temp == 0) p.temp = 1;
        end
        return p;
    endfunction

    // Edges of fields, skip cases, zero coefficient, saturation
    task automatic test_directed();
        particle_t p;
        write_coeff(32'h0);
        send_particle({32'h7FFF_FFFF, 32'h8000_0000, 32'h1234_5678, 32'h0001_0000,
                       32'h0001_0000});
        write_coeff(32'h0001_0000);
        send_particle({32'h1, 32'hFFFF_FFFF, 32'h0, 32'h0001_0000, 32'h0001_0000});
        send_particle({32'h1, 32'h2, 32'h3, 32'h0, 32'h0001_0000});
        send_particle({32'h1, 32'h2, 32'h3, 32'h0001_0000, 32'h8000_0000});
        send_particle({32'h8000_0000, 32'h7FFF_FFFF, 32'h1, 32'h0001_0000, 32'h0004_0000});
        send_particle({32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h0004_0000,
                       32'h0001_0000});
        send_particle({32'h7FFF_FFFF, 32'h8000_0000, 32'h1, 32'h7FFF_FFFF, 32'h7FFF_FFFF});
        send_particle({32'hFFFF_FFFF, 32'h0000_0001, 32'h7FFF_FFFF, 32'h1, 32'h1});
        write_coeff(32'hFFFF_FFFF);
        send_particle({32'h8000_0000, 32'h7FFF_FFFF, 32'h1, 32'h7FFF_FFFF, 32'h7FFF_FFFF});
        send_particle({32'h8000_0001, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h1, 32'h1});
        send_particle({32'h1, 32'h1, 32'h1, 32'h1, 32'h1});
        write_coeff(32'h0000_0001);
        send_particle({32'hFFFF_FFFF, 32'h5555_5555, 32'hAAAA_AAAA, 32'h1, 32'h1});
        send_particle({32'h8000_0001, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                       32'h7FFF_FFFF});
    endtask

    // Random words across several coefficient settings
    task automatic test_random();
        for (int ph = 0; ph < 6; ph++) begin
            write_coeff(ph == 5 ? 32'hFFFF_FFFF : ($urandom >> $urandom_range(31)));
            idle_on = (ph != 2);
            for (int i = 0; i < 100; i++) send_particle(rnd_particle(1));
        end
        idle_on = 1;
    endtask

    // Long receiver stall while the sender keeps offering, then a full drain and unbiased random words
    task automatic test_backpressure();
        hold_off = 200;
        for (int i = 0; i < 80; i++) send_particle(rnd_particle(1));
        drain();
        for (int i = 0; i < 20; i++) send_particle(rnd_particle(0));
    endtask

    // Receiver: random stalls, plus one long forced hold-off
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 0;
        end else if (hold_off > 0) begin
            m_tready <= 0;
            hold_off <= hold_off - 1;
        end else begin
            m_tready <= !(idle_on && $urandom_range(99) < 14);
        end
    end

    // Compare each result word against the oldest expectation
    always @(posedge aclk) begin
        damped_t got;
        damped_t exp_d;
        if (aresetn && m_tvalid && m_tready) begin
            got = {m_tuser, m_tdata};
            n_res++;
            if (damped_q.size() == 0) begin
                $error("unexpected result word %h", got);
                n_err++;
            end else begin
                exp_d = damped_q.pop_front();
                if (exp_d.skip) n_skip++; else n_damped++;
                if (got.mx !== exp_d.mx) begin
                    $error("mom_x_out exp %h got %h", exp_d.mx, got.mx); n_err++;
                end
                if (got.my !== exp_d.my) begin
                    $error("mom_y_out exp %h got %h", exp_d.my, got.my); n_err++;
                end
                if (got.mz !== exp_d.mz) begin
                    $error("mom_z_out exp %h got %h", exp_d.mz, got.mz); n_err++;
                end
                if (got.skip !== exp_d.skip) begin
                    $error("skipped exp %b got %b", exp_d.skip, got.skip); n_err++;
                end
            end
        end
    end

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);
        test_directed();
        test_random();
        test_backpressure();
        drain();
        $display("covered %0d results: %0d damped, %0d skipped, coefficients 0 to max",
                 n_res, n_damped, n_skip);
        if (n_err == 0 && damped_q.size() == 0)
            $display("tb_epstein_drag_velocity_damping passed");
        else
            $display("tb_epstein_drag_velocity_damping failed");
        $finish;
    end

    // Hard stop on hang
    initial begin
        #5ms;
        $display("tb_epstein_drag_velocity_damping failed");
        $finish;
    end
endmodule

// ===== sim.f =====
sv/edvd_pkg.sv
sv/edvd_sqrt.sv
sv/edvd_recip.sv
sv/epstein_drag_velocity_damping.sv
bench/tb_epstein_drag_velocity_damping.sv
